// ===== rtl/tlpc_pkg.sv =====
// ----------------------------------------------------------------------------
// tlpc_pkg: shared constants for the traffic light phase controller
// Register map, reset values, light and pace codes, item and status types.
// ----------------------------------------------------------------------------
package tlpc_pkg;

   localparam int TIME_BITS_DEFAULT  = 8;
   localparam int COUNT_BITS_DEFAULT = TIME_BITS_DEFAULT + 2;

   // configuration port
   localparam int CSR_ADDR_BITS  = 5;
   localparam int CSR_DATA_BITS  = 32;
   localparam int REG_INDEX_BITS = 3;
   localparam int REG_TIMES      = 7;

   localparam logic [REG_INDEX_BITS-1:0] REG_RED         = 3'd0;
   localparam logic [REG_INDEX_BITS-1:0] REG_GREEN       = 3'd1;
   localparam logic [REG_INDEX_BITS-1:0] REG_YELLOW      = 3'd2;
   localparam logic [REG_INDEX_BITS-1:0] REG_DEAD        = 3'd3;
   localparam logic [REG_INDEX_BITS-1:0] REG_REDUCED_RED = 3'd4;
   localparam logic [REG_INDEX_BITS-1:0] REG_REDUCE_LIM  = 3'd5;
   localparam logic [REG_INDEX_BITS-1:0] REG_NO_CHANGE   = 3'd6;
   localparam logic [REG_INDEX_BITS-1:0] REG_START       = 3'd7;

   localparam int TIME_RESET [REG_TIMES] = '{30, 25, 5, 2, 15, 20, 25};
   localparam int START_PHASE_RESET      = 0;

   // request kinds and directions
   localparam logic FUNC_TICK    = 1'b0;
   localparam logic FUNC_REQUEST = 1'b1;
   localparam logic DIR_NS       = 1'b0;
   localparam logic DIR_WE       = 1'b1;

   localparam logic [1:0] LIGHT_RED    = 2'd0;
   localparam logic [1:0] LIGHT_GREEN  = 2'd1;
   localparam logic [1:0] LIGHT_YELLOW = 2'd2;

   localparam logic [1:0] PACE_NORMAL = 2'd0;
   localparam logic [1:0] PACE_ARMED  = 2'd1;
   localparam logic [1:0] PACE_TAKEN  = 2'd2;

   typedef struct packed {
      logic valid;
      logic func;
      logic direction;
   } item_type;

   typedef struct packed {
      logic [1:0] light_ns;
      logic [1:0] light_we;
      logic [1:0] pace_mode;
   } status_type;

endpackage

// ===== rtl/tlpc_if.sv =====
// ----------------------------------------------------------------------------
// tlpc_if: request and result channels
// Valid/ready channels; a transfer completes when valid and ready are high.
// ----------------------------------------------------------------------------
interface tlpc_req_if;
   logic valid;
   logic ready;
   logic func;
   logic direction;

   modport source (output valid, output func, output direction, input ready);
   modport sink   (input valid, input func, input direction, output ready);
endinterface

interface tlpc_rsp_if #(
   parameter int COUNT_BITS = tlpc_pkg::COUNT_BITS_DEFAULT
);
   logic                  valid;
   logic                  ready;
   logic [1:0]            light_ns;
   logic [1:0]            light_we;
   logic [1:0]            pace_mode;
   logic [COUNT_BITS-1:0] phase_count;

   modport source (output valid, output light_ns, output light_we, output pace_mode,
                   output phase_count, input ready);
   modport sink   (input valid, input light_ns, input light_we, input pace_mode,
                   input phase_count, output ready);
endinterface

// ===== rtl/tlpc_csr.sv =====
// ----------------------------------------------------------------------------
// tlpc_csr: configuration registers
// APB-style register file holding the timing thresholds and start phase.
// ----------------------------------------------------------------------------
module tlpc_csr #(
   parameter int TIME_BITS  = tlpc_pkg::TIME_BITS_DEFAULT,
   parameter int COUNT_BITS = TIME_BITS + 2
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    psel,
   input  logic                                    penable,
   input  logic                                    pwrite,
   input  logic [tlpc_pkg::CSR_ADDR_BITS-1:0]      paddr,
   input  logic [tlpc_pkg::CSR_DATA_BITS-1:0]      pwdata,
   output logic [tlpc_pkg::CSR_DATA_BITS-1:0]      prdata,
   output logic                                    pready,
   output logic [tlpc_pkg::REG_TIMES-1:0][TIME_BITS-1:0] times,
   output logic                                    wr_strobe
);

   logic [tlpc_pkg::REG_TIMES-1:0][TIME_BITS-1:0] time_ff, time_in;
   logic [COUNT_BITS-1:0]                         start_phase_ff, start_phase_in;
   logic [tlpc_pkg::REG_INDEX_BITS-1:0]           idx;

   assign pready    = 1'b1;
   assign idx       = paddr[tlpc_pkg::CSR_ADDR_BITS-1:2];
   assign wr_strobe = psel & penable & pwrite;
   assign times     = time_ff;

   always_comb begin
      time_in        = time_ff;
      start_phase_in = start_phase_ff;
      if (wr_strobe) begin
         if (idx == tlpc_pkg::REG_START) begin
            start_phase_in = pwdata[COUNT_BITS-1:0];
         end else begin
            time_in[idx] = pwdata[TIME_BITS-1:0];
         end
      end
   end

   always_comb begin
      if (idx == tlpc_pkg::REG_START) begin
         prdata = tlpc_pkg::CSR_DATA_BITS'(start_phase_ff);
      end else begin
         prdata = tlpc_pkg::CSR_DATA_BITS'(time_ff[idx]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tlpc_pkg::REG_TIMES; i++) begin
            time_ff[i] <= TIME_BITS'(tlpc_pkg::TIME_RESET[i]);
         end
         start_phase_ff <= COUNT_BITS'(tlpc_pkg::START_PHASE_RESET);
      end else begin
         time_ff        <= time_in;
         start_phase_ff <= start_phase_in;
      end
   end

endmodule

// ===== rtl/tlpc_mod_unit.sv =====
// ----------------------------------------------------------------------------
// tlpc_mod_unit: iterative remainder unit
// Restoring division, one dividend bit per cycle; returns the remainder.
// ----------------------------------------------------------------------------
module tlpc_mod_unit #(
   parameter int DIVIDEND_BITS = tlpc_pkg::COUNT_BITS_DEFAULT + 1,
   parameter int DIVISOR_BITS  = tlpc_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DIVIDEND_BITS-1:0] dividend,
   input  logic [DIVISOR_BITS-1:0]  divisor,
   output logic                     done,
   output logic [DIVISOR_BITS-1:0]  remainder
);

   localparam int STEP_BITS = $clog2(DIVIDEND_BITS + 1);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [STEP_BITS-1:0]     step_ff, step_in;
   logic [DIVIDEND_BITS-1:0] dividend_ff, dividend_in;
   logic [DIVISOR_BITS-1:0]  divisor_ff, divisor_in;
   logic [DIVISOR_BITS-1:0]  rem_ff, rem_in;
   logic [DIVISOR_BITS:0]    trial;

   assign trial     = {rem_ff, dividend_ff[DIVIDEND_BITS-1]};
   assign done      = done_ff;
   assign remainder = rem_ff;

   always_comb begin
      busy_in     = busy_ff;
      done_in     = 1'b0;
      step_in     = step_ff;
      dividend_in = dividend_ff;
      divisor_in  = divisor_ff;
      rem_in      = rem_ff;
      if (start) begin
         busy_in     = 1'b1;
         step_in     = STEP_BITS'(DIVIDEND_BITS);
         dividend_in = dividend;
         divisor_in  = divisor;
         rem_in      = '0;
      end else if (busy_ff) begin
         dividend_in = {dividend_ff[DIVIDEND_BITS-2:0], 1'b0};
         if (trial >= {1'b0, divisor_ff}) begin
            rem_in = DIVISOR_BITS'(trial - {1'b0, divisor_ff});
         end else begin
            rem_in = trial[DIVISOR_BITS-1:0];
         end
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      divisor_ff  <= divisor_in;
      rem_ff      <= rem_in;
   end

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("remainder unit restarted while busy");

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("remainder unit done held for more than one cycle");

endmodule

// ===== rtl/tlpc_core.sv =====
// ----------------------------------------------------------------------------
// tlpc_core: phase counter, lights and pace state
// Applies one tick or shortening request per cycle (ticks beyond span wait).
// ----------------------------------------------------------------------------
module tlpc_core #(
   parameter int TIME_BITS  = tlpc_pkg::TIME_BITS_DEFAULT,
   parameter int COUNT_BITS = TIME_BITS + 2
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic [tlpc_pkg::REG_TIMES-1:0][TIME_BITS-1:0] times,
   input  logic                                          cfg_write,
   input  tlpc_pkg::item_type                            item,
   input  logic                                          item_go,
   output logic                                          item_ok,
   output tlpc_pkg::status_type                          status_in,
   output logic [COUNT_BITS-1:0]                         phase_in
);

   localparam int DIV_BITS = COUNT_BITS + 1;

   localparam logic [1:0] FIX_IDLE = 2'd0;
   localparam logic [1:0] FIX_POS  = 2'd1;
   localparam logic [1:0] FIX_NEXT = 2'd2;

   logic [COUNT_BITS-1:0] counter_ff, counter_in;
   logic [1:0]            pace_ff, pace_in;
   logic [1:0]            ns_ff, ns_in;
   logic [1:0]            we_ff, we_in;
   logic [1:0]            fix_state_ff, fix_state_in;
   logic                  fix_valid_ff, fix_valid_in;
   logic [COUNT_BITS-1:0] pos_fix_ff, pos_fix_in;
   logic [COUNT_BITS-1:0] next_fix_ff, next_fix_in;

   logic [TIME_BITS-1:0]  red, green, yellow, dead, reduced_red, reduce_lim, no_change;
   logic [TIME_BITS-1:0]  skip;
   logic [COUNT_BITS-1:0] span, half, gy;
   logic                  beyond;
   logic [COUNT_BITS:0]   c_wide, h1, h2, h3, inc, inc1, inc2, span_w, skip_sum;
   logic [COUNT_BITS-1:0] pos_fast, pos, next_fast, n0, n1, limit;
   logic [1:0]            served, p1, p2;
   logic                  armed_take, req_open;

   logic                  div_start, div_done;
   logic [DIV_BITS-1:0]   div_dividend;
   logic [COUNT_BITS-1:0] div_divisor, div_rem;

   assign red         = times[tlpc_pkg::REG_RED];
   assign green       = times[tlpc_pkg::REG_GREEN];
   assign yellow      = times[tlpc_pkg::REG_YELLOW];
   assign dead        = times[tlpc_pkg::REG_DEAD];
   assign reduced_red = times[tlpc_pkg::REG_REDUCED_RED];
   assign reduce_lim  = times[tlpc_pkg::REG_REDUCE_LIM];
   assign no_change   = times[tlpc_pkg::REG_NO_CHANGE];

   assign span   = COUNT_BITS'(red) + COUNT_BITS'(green) + COUNT_BITS'(yellow);
   assign half   = span >> 1;
   assign gy     = COUNT_BITS'(green) + COUNT_BITS'(yellow);
   assign skip   = (red > reduced_red) ? (red - reduced_red) : '0;
   assign beyond = counter_ff > span;

   // Counter within span: it is below 3*half + 1, so at most three
   // subtractions of half give the position.
   assign c_wide = {1'b0, counter_ff};
   assign h1     = {1'b0, half};
   assign h2     = {half, 1'b0};
   assign h3     = h2 + h1;

   always_comb begin
      if (c_wide >= h3) begin
         pos_fast = COUNT_BITS'(c_wide - h3);
      end else if (c_wide >= h2) begin
         pos_fast = COUNT_BITS'(c_wide - h2);
      end else if (c_wide >= h1) begin
         pos_fast = COUNT_BITS'(c_wide - h1);
      end else begin
         pos_fast = counter_ff;
      end
   end

   assign span_w    = {1'b0, span};
   assign inc       = c_wide + 1'b1;
   assign inc1      = (inc >= span_w) ? (inc - span_w) : inc;
   assign inc2      = (inc1 >= span_w) ? (inc1 - span_w) : inc1;
   assign next_fast = COUNT_BITS'(inc2);

   // beyond span the remainders come from the iterative unit
   assign pos = (half == '0) ? counter_ff : (beyond ? pos_fix_ff : pos_fast);
   assign n0  = (span == '0) ? '0 : (beyond ? next_fix_ff : next_fast);

   always_comb begin
      if (pos < COUNT_BITS'(dead)) begin
         served = tlpc_pkg::LIGHT_RED;
      end else if (pos < COUNT_BITS'(green)) begin
         served = tlpc_pkg::LIGHT_GREEN;
      end else begin
         served = tlpc_pkg::LIGHT_YELLOW;
      end
   end

   assign armed_take = (pace_ff == tlpc_pkg::PACE_ARMED) && (n0 > COUNT_BITS'(dead));
   assign limit      = (n0 < half) ? half : span;
   assign skip_sum   = {1'b0, n0} + (COUNT_BITS + 1)'(skip);

   always_comb begin
      if (armed_take) begin
         n1 = (skip_sum > {1'b0, limit}) ? limit : COUNT_BITS'(skip_sum);
         p1 = tlpc_pkg::PACE_TAKEN;
      end else begin
         n1 = n0;
         p1 = pace_ff;
      end
      if (p1 == tlpc_pkg::PACE_TAKEN && (n1 == '0 || n1 == half)) begin
         p2 = tlpc_pkg::PACE_NORMAL;
      end else begin
         p2 = p1;
      end
   end

   assign req_open = (pace_ff == tlpc_pkg::PACE_NORMAL) && (counter_ff > COUNT_BITS'(dead));

   always_comb begin
      counter_in = counter_ff;
      pace_in    = pace_ff;
      ns_in      = ns_ff;
      we_in      = we_ff;
      if (item_go) begin
         if (item.func == tlpc_pkg::FUNC_TICK) begin
            if (counter_ff < half) begin
               ns_in = served;
               we_in = tlpc_pkg::LIGHT_RED;
            end else begin
               ns_in = tlpc_pkg::LIGHT_RED;
               we_in = served;
            end
            counter_in = n1;
            pace_in    = p2;
         end else if (req_open) begin
            if (item.direction == tlpc_pkg::DIR_NS) begin
               if (ns_ff == tlpc_pkg::LIGHT_RED &&
                   counter_ff <= COUNT_BITS'(no_change) + gy) begin
                  if (counter_ff <= COUNT_BITS'(reduce_lim) + gy) begin
                     pace_in = tlpc_pkg::PACE_ARMED;
                  end else begin
                     counter_in = span - COUNT_BITS'(yellow);
                  end
               end
            end else begin
               if (we_ff == tlpc_pkg::LIGHT_RED && counter_ff <= COUNT_BITS'(no_change)) begin
                  if (counter_ff <= COUNT_BITS'(reduce_lim)) begin
                     pace_in = tlpc_pkg::PACE_ARMED;
                  end else begin
                     counter_in = gy;
                  end
               end
            end
         end
      end
   end

   assign status_in.light_ns  = ns_in;
   assign status_in.light_we  = we_in;
   assign status_in.pace_mode = pace_in;
   assign phase_in            = counter_in;

   // A tick with the counter past span waits for both remainders.
   assign item_ok = !(item.func == tlpc_pkg::FUNC_TICK && beyond) || fix_valid_ff;

   always_comb begin
      fix_state_in = fix_state_ff;
      fix_valid_in = fix_valid_ff;
      pos_fix_in   = pos_fix_ff;
      next_fix_in  = next_fix_ff;
      div_start    = 1'b0;
      div_dividend = c_wide;
      div_divisor  = half;
      case (fix_state_ff)
         FIX_IDLE: begin
            if (item.valid && item.func == tlpc_pkg::FUNC_TICK && beyond && !fix_valid_ff) begin
               div_start    = 1'b1;
               fix_state_in = FIX_POS;
            end
         end
         FIX_POS: begin
            if (div_done) begin
               pos_fix_in   = div_rem;
               div_start    = 1'b1;
               div_dividend = inc;
               div_divisor  = span;
               fix_state_in = FIX_NEXT;
            end
         end
         FIX_NEXT: begin
            if (div_done) begin
               next_fix_in  = div_rem;
               fix_valid_in = 1'b1;
               fix_state_in = FIX_IDLE;
            end
         end
         default: begin
            fix_state_in = FIX_IDLE;
         end
      endcase
      if (item_go || cfg_write) begin
         fix_valid_in = 1'b0;
      end
   end

   tlpc_mod_unit #(
      .DIVIDEND_BITS (DIV_BITS),
      .DIVISOR_BITS  (COUNT_BITS)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff   <= COUNT_BITS'(tlpc_pkg::START_PHASE_RESET);
         pace_ff      <= tlpc_pkg::PACE_NORMAL;
         ns_ff        <= tlpc_pkg::LIGHT_RED;
         we_ff        <= tlpc_pkg::LIGHT_RED;
         fix_state_ff <= FIX_IDLE;
         fix_valid_ff <= 1'b0;
      end else begin
         counter_ff   <= counter_in;
         pace_ff      <= pace_in;
         ns_ff        <= ns_in;
         we_ff        <= we_in;
         fix_state_ff <= fix_state_in;
         fix_valid_ff <= fix_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_fix_ff  <= pos_fix_in;
      next_fix_ff <= next_fix_in;
   end

   a_tick_in_span: assert property (@(posedge clock) disable iff (reset)
      item_go && item.func == tlpc_pkg::FUNC_TICK |=> counter_ff <= $past(span))
      else $error("counter left beyond span after a tick");

   a_fix_idle: assert property (@(posedge clock) disable iff (reset)
      fix_valid_ff |-> fix_state_ff == FIX_IDLE)
      else $error("remainders marked valid while still being computed");

   a_request_no_take: assert property (@(posedge clock) disable iff (reset)
      item_go && item.func == tlpc_pkg::FUNC_REQUEST && pace_ff != tlpc_pkg::PACE_TAKEN
      |=> pace_ff != tlpc_pkg::PACE_TAKEN)
      else $error("shortening request marked the skip as taken");

endmodule

// ===== rtl/traffic_light_phase_controller_top.sv =====
// ----------------------------------------------------------------------------
// traffic_light_phase_controller_top: two-way crossing light controller
// Each request is a one-second tick or a red-shortening request for one
// direction; each one returns one result with both lights, the pace mode and
// the phase counter after the step.
// Channels: req_ch (sink) and rsp_ch (source), valid/ready; thresholds are
// written over the APB-style port, by the user only while no request is in
// flight; the block itself does not enforce this. A taken request is held
// in the input register, and its result in the result register, which drives
// rsp_ch. Throughput is one request per cycle while rsp_ch does not stall, set
// by the single state update between the two registers. The other exception
// is a tick while the counter lies beyond span (after the thresholds were
// shortened): that tick waits while the iterative remainder unit runs twice.
// Reset: counter at the start phase reset value, pace normal, both lights red,
// registers at their reset values; no clearing pass.
// A stalled rsp_ch holds its result; one further request is still taken into
// the input register, after which req_ch.ready drops.
// ----------------------------------------------------------------------------
module traffic_light_phase_controller_top #(
   parameter int TIME_BITS = tlpc_pkg::TIME_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   tlpc_req_if.sink                           req_ch,
   tlpc_rsp_if.source                         rsp_ch,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [tlpc_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [tlpc_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [tlpc_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                               pready
);

   localparam int COUNT_BITS = TIME_BITS + 2;

   logic [tlpc_pkg::REG_TIMES-1:0][TIME_BITS-1:0] times;
   logic                  wr_strobe;
   tlpc_pkg::item_type    item_ff, item_in;
   logic                  item_ok, advance, out_free;
   tlpc_pkg::status_type  status_in, status_ff;
   logic [COUNT_BITS-1:0] phase_in, phase_ff;
   logic                  rsp_valid_ff, rsp_valid_in;

   tlpc_csr #(
      .TIME_BITS  (TIME_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .times     (times),
      .wr_strobe (wr_strobe)
   );

   tlpc_core #(
      .TIME_BITS  (TIME_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .times     (times),
      .cfg_write (wr_strobe),
      .item      (item_ff),
      .item_go   (advance),
      .item_ok   (item_ok),
      .status_in (status_in),
      .phase_in  (phase_in)
   );

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign advance      = item_ff.valid && item_ok && out_free;
   assign req_ch.ready = !item_ff.valid || advance;

   always_comb begin
      item_in = item_ff;
      if (req_ch.ready) begin
         item_in.valid     = req_ch.valid;
         item_in.func      = req_ch.func;
         item_in.direction = req_ch.direction;
      end
   end

   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      item_ff.func      <= item_in.func;
      item_ff.direction <= item_in.direction;
      if (reset) begin
         item_ff.valid <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_ff.valid <= item_in.valid;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         status_ff <= status_in;
         phase_ff  <= phase_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.light_ns    = status_ff.light_ns;
   assign rsp_ch.light_we    = status_ff.light_we;
   assign rsp_ch.pace_mode   = status_ff.pace_mode;
   assign rsp_ch.phase_count = phase_ff;

   a_result_from_item: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance))
      else $error("result appeared without a request being processed");

endmodule
